// File: hw/rtl/rar_pkg.sv
// shared types and constants for the rational arithmetic reduction unit
package rar_pkg;

	// result field width
	localparam int RES_W = 33;

	// operation codes
	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_SUB = 2'd1,
		FN_MUL = 2'd2,
		FN_DIV = 2'd3
	} rar_func_t;

	// classification flags passed from front to back with each item
	typedef struct packed {
		logic num_zero;
		logic den_zero;
	} rar_flags_t;

endpackage

// File: hw/rtl/rar_front.sv
// front part: accepts items, forms cross products and classifies them
module rar_front import rar_pkg::*; #(
	parameter int W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             func,
	input  logic signed [W-1:0]    a_num,
	input  logic signed [W-1:0]    a_den,
	input  logic signed [W-1:0]    b_num,
	input  logic signed [W-1:0]    b_den,
	output logic                   push,
	input  logic                   q_full,
	output rar_flags_t             push_flags,
	output logic signed [2*W:0]    push_num,
	output logic signed [2*W-1:0]  push_den
);

	logic                  v_s1, v_s2, adv;
	rar_func_t             fn_s1, fn_s2;
	logic signed [W-1:0]   x1_s1, y1_s1, x2_s1, y2_s1, xd_s1, yd_s1;
	logic signed [2*W-1:0] p1_s2, p2_s2, pd_s2;
	logic signed [2*W:0]   num;

	// pipeline moves unless a finished item waits on a full queue
	assign adv      = !v_s2 || !q_full;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// operand selection by operation
	always_ff @(posedge clk) begin
		if (adv) begin
			fn_s1 <= rar_func_t'(func);
			x1_s1 <= a_num;
			y1_s1 <= (rar_func_t'(func) == FN_MUL) ? b_num : b_den;
			x2_s1 <= b_num;
			y2_s1 <= a_den;
			xd_s1 <= a_den;
			yd_s1 <= (rar_func_t'(func) == FN_DIV) ? b_num : b_den;
		end
	end

	// three products in parallel
	always_ff @(posedge clk) begin
		if (adv) begin
			fn_s2 <= fn_s1;
			p1_s2 <= (2*W)'(x1_s1) * (2*W)'(y1_s1);
			p2_s2 <= (2*W)'(x2_s1) * (2*W)'(y2_s1);
			pd_s2 <= (2*W)'(xd_s1) * (2*W)'(yd_s1);
		end
	end

	// combine numerator terms and classify
	always_comb begin
		case (fn_s2)
			FN_ADD:  num = (2*W+1)'(p1_s2) + (2*W+1)'(p2_s2);
			FN_SUB:  num = (2*W+1)'(p1_s2) - (2*W+1)'(p2_s2);
			default: num = (2*W+1)'(p1_s2);
		endcase
	end

	assign push                = v_s2 && !q_full;
	assign push_num            = num;
	assign push_den            = pd_s2;
	assign push_flags.num_zero = (num == '0);
	assign push_flags.den_zero = (pd_s2 == '0);

endmodule

// File: hw/rtl/rar_queue.sv
// two-entry item queue between front and back
module rar_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/rar_back.sv
// back part: binary gcd, division by the gcd and result register
module rar_back import rar_pkg::*; #(
	parameter int W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_avail,
	output logic                     pop,
	input  rar_flags_t               q_flags,
	input  logic signed [2*W:0]      q_num,
	input  logic signed [2*W-1:0]    q_den,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RES_W-1:0]  res_num,
	output logic signed [RES_W-1:0]  res_den,
	output logic                     div_zero
);

	localparam int MW = 2 * W;
	localparam int KW = $clog2(MW + 1);
	localparam int CW = $clog2(MW);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_GCD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t             st_q;
	rar_flags_t      fl_q;
	logic            neg_n_q, neg_d_q, ov_q, load;
	logic [MW-1:0]   u_q, v_q, g_q, mn_q, md_q, rn_q, rd_q, d_uv;
	logic [KW-1:0]   k_q;
	logic [CW-1:0]   cnt_q;
	logic [MW:0]     rn_t, rd_t;
	logic [2*W:0]    abs_n;
	logic [2*W-1:0]  abs_d;
	logic signed [MW:0] sn, sd;

	assign abs_n = q_num[2*W] ? -q_num : q_num;
	assign abs_d = q_den[2*W-1] ? -q_den : q_den;
	assign pop   = (st_q == ST_IDLE) && q_avail;
	assign load  = (st_q == ST_DONE) && (!ov_q || !out_stall);
	assign d_uv  = (u_q >= v_q) ? (u_q - v_q) : (v_q - u_q);

	// restoring division trial values
	assign rn_t = {rn_q, mn_q[MW-1]};
	assign rd_t = {rd_q, md_q[MW-1]};

	// signed quotients
	assign sn = neg_n_q ? -$signed({1'b0, mn_q}) : $signed({1'b0, mn_q});
	assign sd = neg_d_q ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (pop) begin
					st_q <= (q_flags.num_zero || q_flags.den_zero) ? ST_DONE : ST_GCD;
				end
				ST_GCD: if (u_q == '0 || v_q == '0) begin
					st_q <= ST_DIV;
				end
				ST_DIV: if (cnt_q == CW'(MW - 1)) begin
					st_q <= ST_DONE;
				end
				ST_DONE: if (load) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				fl_q    <= q_flags;
				neg_n_q <= q_num[2*W];
				neg_d_q <= q_den[2*W-1];
				u_q     <= MW'(abs_n);
				v_q     <= abs_d;
				mn_q    <= MW'(abs_n);
				md_q    <= abs_d;
				k_q     <= '0;
			end
			ST_GCD: begin
				// one binary gcd step
				if (u_q == '0 || v_q == '0) begin
					g_q   <= MW'((u_q | v_q) << k_q);
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= d_uv >> 1;
				end else begin
					v_q <= d_uv >> 1;
				end
			end
			ST_DIV: begin
				// one quotient bit per lane
				cnt_q <= cnt_q + 1'b1;
				if (rn_t >= {1'b0, g_q}) begin
					rn_q <= MW'(rn_t - {1'b0, g_q});
					mn_q <= {mn_q[MW-2:0], 1'b1};
				end else begin
					rn_q <= MW'(rn_t);
					mn_q <= {mn_q[MW-2:0], 1'b0};
				end
				if (rd_t >= {1'b0, g_q}) begin
					rd_q <= MW'(rd_t - {1'b0, g_q});
					md_q <= {md_q[MW-2:0], 1'b1};
				end else begin
					rd_q <= MW'(rd_t);
					md_q <= {md_q[MW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			if (fl_q.den_zero) begin
				res_num  <= '0;
				res_den  <= '0;
				div_zero <= 1'b1;
			end else if (fl_q.num_zero) begin
				res_num  <= '0;
				res_den  <= RES_W'(1);
				div_zero <= 1'b0;
			end else begin
				res_num  <= RES_W'(sn);
				res_den  <= RES_W'(sd);
				div_zero <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

endmodule

// File: hw/rtl/rational_arith_reduce_unit.sv
// rational arithmetic with reduction to lowest terms, top level
// throughput is set by the gcd and divider sequencer of the back part, which takes a new
// item only when idle; front and two-entry queue run ahead of it
// items with a zero combined numerator or denominator skip gcd and division
// reset: asynchronous, active low, clears valid flags, queue count and sequencer state
module rational_arith_reduce_unit import rar_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic signed [OPERAND_WIDTH-1:0]  a_num,
	input  logic signed [OPERAND_WIDTH-1:0]  a_den,
	input  logic signed [OPERAND_WIDTH-1:0]  b_num,
	input  logic signed [OPERAND_WIDTH-1:0]  b_den,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [RES_W-1:0]          res_num,
	output logic signed [RES_W-1:0]          res_den,
	output logic                             div_zero
);

	localparam int W  = OPERAND_WIDTH;
	localparam int DW = $bits(rar_flags_t) + (2*W + 1) + 2*W;

	logic                 push, q_full, q_avail, pop;
	rar_flags_t           push_flags, q_flags;
	logic signed [2*W:0]  push_num, q_num;
	logic signed [2*W-1:0] push_den, q_den;
	logic [DW-1:0]        q_rdata;

	// classification and products
	rar_front #(.W(W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.a_num      (a_num),
		.a_den      (a_den),
		.b_num      (b_num),
		.b_den      (b_den),
		.push       (push),
		.q_full     (q_full),
		.push_flags (push_flags),
		.push_num   (push_num),
		.push_den   (push_den)
	);

	// decoupling queue
	rar_queue #(.DW(DW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_flags, push_num, push_den}),
		.full   (q_full),
		.pop    (pop),
		.avail  (q_avail),
		.rdata  (q_rdata)
	);

	assign {q_flags, q_num, q_den} = q_rdata;

	// reduction
	rar_back #(.W(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.pop       (pop),
		.q_flags   (q_flags),
		.q_num     (q_num),
		.q_den     (q_den),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_num   (res_num),
		.res_den   (res_den),
		.div_zero  (div_zero)
	);

endmodule

// File: hw/rtl/rar_checker.sv
// port level checks for the rational arithmetic reduction unit
module rar_checker import rar_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [RES_W-1:0] res_num,
	input logic signed [RES_W-1:0] res_den,
	input logic                    div_zero
);

	// stalled item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den)
			&& $stable(div_zero))
		else $error("stalled result changed");

	// division by zero gives zero fields
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_num == '0 && res_den == '0)
		else $error("div_zero with nonzero fields");

	// zero result is reported as 0/1
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_zero && res_num == '0 |-> res_den == RES_W'(1))
		else $error("zero result not 0/1");

	// valid result never has a zero denominator
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_zero |-> res_den != '0)
		else $error("zero denominator without div_zero");

endmodule

bind rational_arith_reduce_unit rar_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.res_num   (res_num),
	.res_den   (res_den),
	.div_zero  (div_zero)
);
